### design/stable_sorted_priority_queue_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Checked after reset has been released.
`define SSPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define SSPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/sspq_pkg.sv
`default_nettype none

package sspq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned FILL_W       = 5;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 48;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_HOLD
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic    do_insert;
    logic    do_remove;
    logic    load_res;
    status_e res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } sts_t;

endpackage

`default_nettype wire

### design/sspq_ctrl.sv
`default_nettype none

module sspq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  input  wire logic          op_i,
  input  wire logic          m_ready_i,
  input  sspq_pkg::sts_t     sts_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  output sspq_pkg::cmd_t     cmd_o
);
  import sspq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    m_valid_o = 1'b0;
    s_ready_o = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        s_ready_o = 1'b1;
      end
      CTRL_HOLD: begin
        m_valid_o = 1'b1;
        // result register frees up in the same cycle it is taken
        s_ready_o = m_ready_i;
      end
    endcase
    accept = s_valid_i && s_ready_o;

    if (accept) begin
      state_d = CTRL_HOLD;
    end else if (state_q == CTRL_HOLD && m_ready_i) begin
      state_d = CTRL_IDLE;
    end

    cmd_o            = '0;
    cmd_o.load_res   = accept;
    cmd_o.res_status = STATUS_DONE;
    if (accept) begin
      if (op_i == OP_INSERT) begin
        if (sts_i.full) begin
          cmd_o.res_status = STATUS_FULL;
        end else begin
          cmd_o.do_insert = 1'b1;
        end
      end else begin
        if (sts_i.empty) begin
          cmd_o.res_status = STATUS_EMPTY;
        end else begin
          cmd_o.do_remove = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/sspq_datapath.sv
`default_nettype none

module sspq_datapath #(
  parameter int unsigned CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  sspq_pkg::cmd_t                      cmd_i,
  input  wire logic [sspq_pkg::VALUE_W-1:0]   item_value_i,
  input  wire logic [sspq_pkg::PRIO_W-1:0]    item_prio_i,
  output sspq_pkg::sts_t                      sts_o,
  output logic [sspq_pkg::VALUE_W-1:0]        out_value_o,
  output logic [sspq_pkg::PRIO_W-1:0]         out_prio_o,
  output logic [sspq_pkg::STATUS_W-1:0]       status_o,
  output logic [sspq_pkg::FILL_W-1:0]         fill_count_o
);
  import sspq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] val_q  [CAPACITY];
  logic [PRIO_W-1:0]  prio_q [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_ge;

  logic [VALUE_W-1:0]  res_value_q;
  logic [PRIO_W-1:0]   res_prio_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [FILL_W-1:0]   res_fill_q;
  logic [31:0]         count_ext;

  // Each cell: insert takes the new item at the first slot that is empty or whose
  // priority is below the incoming one, cells past it shift right; remove shifts left.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic left_ge;
    logic left_valid;
    logic [VALUE_W-1:0] left_val, right_val;
    logic [PRIO_W-1:0]  left_prio, right_prio;

    assign cell_valid[i] = IDX < count_q;
    assign cell_ge[i]    = cell_valid[i] && (prio_q[i] >= item_prio_i);

    if (i == 0) begin : g_head
      assign left_ge    = 1'b1;
      assign left_valid = 1'b0;
      assign left_val   = item_value_i;
      assign left_prio  = item_prio_i;
    end else begin : g_body
      assign left_ge    = cell_ge[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_val   = val_q[i-1];
      assign left_prio  = prio_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val  = val_q[i];
      assign right_prio = prio_q[i];
    end else begin : g_inner
      assign right_val  = val_q[i+1];
      assign right_prio = prio_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.do_insert && !cell_ge[i]) begin
        if (left_ge) begin
          val_q[i]  <= item_value_i;
          prio_q[i] <= item_prio_i;
        end else if (left_valid) begin
          val_q[i]  <= left_val;
          prio_q[i] <= left_prio;
        end
      end else if (cmd_i.do_remove) begin
        val_q[i]  <= right_val;
        prio_q[i] <= right_prio;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.do_remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_value_q  <= cmd_i.do_remove ? val_q[0]  : '0;
      res_prio_q   <= cmd_i.do_remove ? prio_q[0] : '0;
      res_status_q <= cmd_i.res_status;
      res_fill_q   <= count_ext[FILL_W-1:0];
    end
  end

  assign sts_o.full   = count_q == CNT_W'(CAPACITY);
  assign sts_o.empty  = count_q == '0;
  assign out_value_o  = res_value_q;
  assign out_prio_o   = res_prio_q;
  assign status_o     = res_status_q;
  assign fill_count_o = res_fill_q;

endmodule

`default_nettype wire

### design/stable_sorted_priority_queue_unit.sv
// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   item_value[31:0] item_prio[39:32]          op
// m_axis    out  out_value[31:0] out_prio[39:32]            status[1:0]
//                fill_count[44:40] zero[47:45]
//
// For every beat the whole row of cells compares the incoming priority and
// shifts in parallel, so one item per cycle is sustained while m_axis is ready.
// The result shows on m_axis in the cycle after the input beat.
// A new beat is taken while the result register is empty or being drained.
// Reset clears the fill count and the controller state; no clearing pass,
// the block is ready at once.
`default_nettype none

module stable_sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [sspq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // item_value, item_prio
  input  wire logic [0:0]                        s_axis_tuser,  // op
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [sspq_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // out_value, out_prio, fill_count
  output logic [sspq_pkg::STATUS_W-1:0]          m_axis_tuser   // status
);
  import sspq_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [VALUE_W-1:0]  out_value;
  logic [PRIO_W-1:0]   out_prio;
  logic [FILL_W-1:0]   fill_count;

  sspq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (s_axis_tuser[0]),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  sspq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_value_i (s_axis_tdata[VALUE_W-1:0]),
    .item_prio_i  (s_axis_tdata[VALUE_W+PRIO_W-1:VALUE_W]),
    .sts_o        (sts),
    .out_value_o  (out_value),
    .out_prio_o   (out_prio),
    .status_o     (m_axis_tuser),
    .fill_count_o (fill_count)
  );

  assign m_axis_tdata = {3'b000, fill_count, out_prio, out_value};

endmodule

`default_nettype wire

### design/sspq_checker.sv
`default_nettype none
`include "stable_sorted_priority_queue_unit_defines.svh"

module sspq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [sspq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [sspq_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import sspq_pkg::*;

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  `SSPQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  `SSPQ_ASSERT(a_no_overrun, in_beat && m_axis_tvalid |-> m_axis_tready, "input taken over a waiting result")

  `SSPQ_ASSERT(a_beat_gives_result, in_beat |=> m_axis_tvalid, "no result after input beat")

  `SSPQ_ASSERT(a_fail_no_payload, m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY || m_axis_tuser == STATUS_FULL) |-> m_axis_tdata[39:0] == '0, "failed op returned a payload")

  `SSPQ_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### bench/tb_stable_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue_unit;
  import sspq_pkg::*;

  localparam int unsigned CAP         = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    status_e            status;
    logic [FILL_W-1:0]  fill;
  } pq_result_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_TDATA_W-1:0]    s_axis_tdata  = '0;
  logic [0:0]               s_axis_tuser  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]      m_axis_tuser;

  // shadow copy of the sorted list, slot 0 is the head
  logic [VALUE_W-1:0] shadow_values [CAP];
  logic [PRIO_W-1:0]  shadow_prios  [CAP];
  int unsigned        shadow_count = 0;

  pq_result_t  pending_results[$];
  int unsigned error_cnt    = 0;
  int unsigned cycle_cnt    = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int unsigned rx_stall_left = 0;

  stable_sorted_priority_queue_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio(int unsigned mode);
    case (mode)
      0: return PRIO_W'($urandom_range(0, 3));
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      2: return PRIO_W'($urandom_range(100, 103));
      default: return PRIO_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void predict_beat(op_e op, logic [VALUE_W-1:0] val,
                                       logic [PRIO_W-1:0] prio);
    pq_result_t  res;
    int unsigned pos;
    res = '{value: '0, prio: '0, status: STATUS_DONE, fill: '0};
    if (op == OP_INSERT) begin
      if (shadow_count >= CAP) begin
        res.status = STATUS_FULL;
      end else begin
        pos = 0;
        // equal priorities stay ahead of the newcomer
        while (pos < shadow_count && shadow_prios[pos] >= prio) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) begin
          shadow_values[i] = shadow_values[i-1];
          shadow_prios[i]  = shadow_prios[i-1];
        end
        shadow_values[pos] = val;
        shadow_prios[pos]  = prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.value = shadow_values[0];
        res.prio  = shadow_prios[0];
        for (int unsigned i = 1; i < shadow_count; i++) begin
          shadow_values[i-1] = shadow_values[i];
          shadow_prios[i-1]  = shadow_prios[i];
        end
        shadow_count--;
      end
    end
    res.fill = shadow_count[FILL_W-1:0];
    pending_results.push_back(res);
  endfunction

  // ends on the rising edge that takes the beat
  task automatic send_item(op_e op, logic [VALUE_W-1:0] val, logic [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = idle_len(tx_gaps_on);
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = IN_TDATA_W'({$urandom, $urandom});
      s_axis_tuser  = 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {prio, val};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat(op, val, prio);
  endtask

  task automatic send_random_item(int unsigned insert_pct, int unsigned prio_mode);
    if ($urandom_range(0, 99) < insert_pct)
      send_item(OP_INSERT, $urandom, pick_prio(prio_mode));
    else
      send_item(OP_REMOVE, $urandom, PRIO_W'($urandom_range(0, 255)));
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_remove_on_empty();
    send_item(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_REMOVE, 32'h0000_0000, 8'h00);
  endtask

  task automatic test_fill_to_capacity();
    logic [VALUE_W-1:0] val;
    logic [PRIO_W-1:0]  prio;
    for (int unsigned i = 0; i < CAP; i++) begin
      case (i)
        0: val = 32'h7FFF_FFFF;
        1: val = 32'h8000_0000;
        2: val = 32'h0000_0000;
        3: val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      // repeated priorities check arrival order among equals
      case (i % 4)
        0: prio = 8'd255;
        1: prio = 8'd0;
        2: prio = 8'd128;
        default: prio = 8'd255;
      endcase
      send_item(OP_INSERT, val, prio);
    end
    send_item(OP_INSERT, 32'h1234_5678, 8'd255);
  endtask

  task automatic test_partial_drain();
    repeat (6) send_item(OP_REMOVE, $urandom, PRIO_W'($urandom_range(0, 255)));
  endtask

  task automatic test_back_to_back();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (40) send_random_item(80, 0);
    repeat (40) send_random_item(20, 3);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (12) send_random_item(70, 3);
    wait_results_drained();
    repeat (12) send_random_item(30, 1);
  endtask

  // random walk of the fill level between empty and full
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned insert_pct;
    int unsigned prio_mode;
    sent = 0;
    while (sent < n_items) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 50;
        default: insert_pct = 20;
      endcase
      prio_mode    = $urandom_range(0, 3);
      tx_gaps_on   = ($urandom_range(0, 4) != 0);
      rx_stalls_on = ($urandom_range(0, 4) != 0);
      repeat (seg_len) begin
        send_random_item(insert_pct, prio_mode);
        sent++;
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  always @(negedge clk_i) begin
    if (rx_stall_left != 0) begin
      m_axis_tready = 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready = 1'b1;
      rx_stall_left = idle_len(rx_stalls_on);
    end
  end

  always @(posedge clk_i) begin
    pq_result_t exp_res;
    pq_result_t got_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = '{value:  m_axis_tdata[31:0],
                  prio:   m_axis_tdata[39:32],
                  status: status_e'(m_axis_tuser),
                  fill:   m_axis_tdata[44:40]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat value=%0h prio=%0h status=%0d fill=%0d", $time,
                 got_res.value, got_res.prio, got_res.status, got_res.fill);
        error_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res !== exp_res || m_axis_tdata[47:45] !== 3'b000) begin
          $display("%0t: mismatch expected value=%0h prio=%0h status=%0d fill=%0d pad=0",
                   $time, exp_res.value, exp_res.prio, exp_res.status, exp_res.fill);
          $display("%0t:          actual   value=%0h prio=%0h status=%0d fill=%0d pad=%0h",
                   $time, got_res.value, got_res.prio, got_res.status, got_res.fill,
                   m_axis_tdata[47:45]);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_stable_sorted_priority_queue_unit NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_remove_on_empty();
    test_fill_to_capacity();
    test_partial_drain();
    test_back_to_back();
    test_pause_until_drained();
    test_random_traffic(1600);

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_stable_sorted_priority_queue_unit OK");
    end else begin
      $display("tb_stable_sorted_priority_queue_unit NOT OK");
    end
    $finish;
  end

endmodule

### stable_sorted_priority_queue_unit.f
+incdir+design
design/sspq_pkg.sv
design/sspq_ctrl.sv
design/sspq_datapath.sv
design/stable_sorted_priority_queue_unit.sv
design/sspq_checker.sv
bench/tb_stable_sorted_priority_queue_unit.sv
